@@ src/rrbc_pkg.sv @@
// Package: shared constants and types for the RTCP REMB bitrate capper.
package rrbc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CAP_W    = 63;
    localparam int unsigned MANT_W   = 18;
    localparam int unsigned EXP_W    = 6;
    localparam int unsigned WIDX_W   = 17;
    localparam int unsigned LEN_W    = 16;

    localparam logic [MANT_W-1:0] MANT_MAX  = 18'h3FFFF;
    localparam logic [EXP_W-1:0]  EXP_LIMIT = 6'd46;
    localparam logic [1:0]        RTCP_VERSION = 2'd2;
    localparam logic [7:0]        PT_PSFB   = 8'd206;
    localparam logic [4:0]        FMT_AFB   = 5'd15;
    localparam logic [WORD_W-1:0] REMB_ID   = {8'h52, 8'h45, 8'h4D, 8'h42};
    localparam logic [WIDX_W-1:0] IDX_REMB_ID   = 17'd3;
    localparam logic [WIDX_W-1:0] IDX_REMB_RATE = 17'd4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CAP_W-1:0]  cap_t;

    typedef struct packed {
        word_t word;
        logic  last;
        logic  capped;
    } result_t;

endpackage

@@ src/rrbc_ifs.sv @@
// Interfaces: packet word, result word and cap write channels.
interface rrbc_word_if
    import rrbc_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t packet_word;
    logic  is_last;

    modport source (output valid, output packet_word, output is_last, input ready);
    modport sink   (input valid, input packet_word, input is_last, output ready);
endinterface

interface rrbc_result_if
    import rrbc_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t out_word;
    logic  out_last;
    logic  was_capped;

    modport source (output valid, output out_word, output out_last, output was_capped,
                    input ready);
    modport sink   (input valid, input out_word, input out_last, input was_capped,
                    output ready);
endinterface

interface rrbc_cfg_if
    import rrbc_pkg::*;
;
    logic valid;
    logic ready;
    cap_t cap_bitrate;

    modport source (output valid, output cap_bitrate, input ready);
    modport sink   (input valid, input cap_bitrate, output ready);
endinterface

@@ src/rtcp_remb_bitrate_capper_top.sv @@
// Top level: RTCP REMB bitrate capper, one packet word in and one word out per request.
// The result is registered on pkt_out; throughput 1 word per cycle while the skid register is empty and no search runs.
// A result register plus a skid register keep input flowing while a result is stalled.
// A cap write starts a serial exponent search; input stalls meanwhile.
// Reset: cap is 0 (pass-through), walk restarts at packet start, pipeline empty.
module rtcp_remb_bitrate_capper_top
    import rrbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rrbc_word_if.sink            pkt_in,
    rrbc_result_if.source        pkt_out,
    rrbc_cfg_if.sink             cfg
);

    // walk state
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              cand_reg, cand_next;
    logic              id_seen_reg, id_seen_next;
    logic              stopped_reg, stopped_next;
    logic              start_reg, start_next;

    // cap and encoder
    cap_t              cap_reg;
    logic              enc_busy_reg;
    cap_t              enc_shift_reg;
    logic              enc_sticky_reg;
    logic [EXP_W-1:0]  enc_exp_reg;
    logic              enc_more;

    // output side
    logic              out_valid_reg, skid_valid_reg;
    result_t           out_reg, skid_reg;
    result_t           res;
    logic              in_fire;
    logic              out_free;

    logic [EXP_W-1:0]  rate_exp;
    cap_t              rate_mant;
    cap_t              cap_shifted;

    assign cfg.ready    = 1'b1;
    assign pkt_in.ready = !skid_valid_reg && !enc_busy_reg;
    assign in_fire      = pkt_in.valid && pkt_in.ready;
    assign out_free     = !out_valid_reg || pkt_out.ready;

    assign pkt_out.valid      = out_valid_reg;
    assign pkt_out.out_word   = out_reg.word;
    assign pkt_out.out_last   = out_reg.last;
    assign pkt_out.was_capped = out_reg.capped;

    assign rate_exp    = pkt_in.packet_word[MANT_W +: EXP_W];
    assign rate_mant   = {{(CAP_W-MANT_W){1'b0}}, pkt_in.packet_word[MANT_W-1:0]};
    assign cap_shifted = cap_reg >> rate_exp;

    // cap > MANT_MAX * 2^b, from floor(cap / 2^b) and the bits shifted out
    assign enc_more = (enc_exp_reg < EXP_LIMIT) &&
        ((enc_shift_reg > {{(CAP_W-MANT_W){1'b0}}, MANT_MAX}) ||
         ((enc_shift_reg == {{(CAP_W-MANT_W){1'b0}}, MANT_MAX}) && enc_sticky_reg));

    always_comb
    begin
        logic w_stop;
        w_stop       = stopped_reg;
        widx_next    = widx_reg;
        len_next     = len_reg;
        cand_next    = cand_reg;
        id_seen_next = id_seen_reg;
        start_next   = start_reg;
        res.word     = pkt_in.packet_word;
        res.last     = pkt_in.is_last;
        res.capped   = 1'b0;

        if (start_reg)
        begin
            start_next = 1'b0;
            if (pkt_in.packet_word[31:30] != RTCP_VERSION)
            begin
                w_stop = 1'b1;
            end
        end

        if (!w_stop)
        begin
            if (widx_reg == '0)
            begin
                len_next     = pkt_in.packet_word[LEN_W-1:0];
                cand_next    = (pkt_in.packet_word[23:16] == PT_PSFB) &&
                               (pkt_in.packet_word[28:24] == FMT_AFB);
                id_seen_next = 1'b0;
            end
            else if (widx_reg == IDX_REMB_ID && cand_reg)
            begin
                id_seen_next = (pkt_in.packet_word == REMB_ID);
            end
            else if (widx_reg == IDX_REMB_RATE && cand_reg && id_seen_reg &&
                     cap_reg != '0)
            begin
                if (rate_mant > cap_shifted)
                begin
                    res.word   = {pkt_in.packet_word[31:24], enc_exp_reg,
                                  enc_shift_reg[MANT_W-1:0]};
                    res.capped = 1'b1;
                end
            end

            if ({1'b0, widx_reg} >= {2'b00, len_next})
            begin
                if (len_next == '0)
                begin
                    w_stop = 1'b1;
                end
                widx_next = '0;
            end
            else
            begin
                widx_next = widx_reg + 1'b1;
            end
        end

        stopped_next = w_stop;

        if (pkt_in.is_last)
        begin
            widx_next    = '0;
            len_next     = '0;
            cand_next    = 1'b0;
            id_seen_next = 1'b0;
            stopped_next = 1'b0;
            start_next   = 1'b1;
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg    <= '0;
            len_reg     <= '0;
            cand_reg    <= 1'b0;
            id_seen_reg <= 1'b0;
            stopped_reg <= 1'b0;
            start_reg   <= 1'b1;
        end
        else if (in_fire)
        begin
            widx_reg    <= widx_next;
            len_reg     <= len_next;
            cand_reg    <= cand_next;
            id_seen_reg <= id_seen_next;
            stopped_reg <= stopped_next;
            start_reg   <= start_next;
        end
    end

    // cap register and serial exponent search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= '0;
            enc_busy_reg   <= 1'b0;
            enc_shift_reg  <= '0;
            enc_sticky_reg <= 1'b0;
            enc_exp_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            cap_reg        <= cfg.cap_bitrate;
            enc_busy_reg   <= 1'b1;
            enc_shift_reg  <= cfg.cap_bitrate;
            enc_sticky_reg <= 1'b0;
            enc_exp_reg    <= '0;
        end
        else if (enc_busy_reg)
        begin
            if (enc_more)
            begin
                enc_sticky_reg <= enc_sticky_reg | enc_shift_reg[0];
                enc_shift_reg  <= enc_shift_reg >> 1;
                enc_exp_reg    <= enc_exp_reg + 1'b1;
            end
            else
            begin
                enc_busy_reg <= 1'b0;
            end
        end
    end

    // result register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= res;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

endmodule

@@ sim/rtcp_remb_bitrate_capper_top_tb.sv @@
// Testbench: REMB bitrate capper, directed and random packet streams checked by hand-computed results or a predictor.
`timescale 1ns / 1ps

module rtcp_remb_bitrate_capper_top_tb
    import rrbc_pkg::*;
;

    localparam int STALL_LIMIT = 2000;

    typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic [62:0] value;
        logic        last;
        logic        hard_exp;
        word_t       exp_word;
        logic        exp_capped;
    } stim_row_t;

    // hard_exp rows carry a hand-computed result; the rest go through the predictor
    localparam stim_row_t STIM_ROWS [30] = '{
        '{ROW_WORD, 63'h8FCE0004, 1'b0, 1'b1, 32'h8FCE0004, 1'b0},
        '{ROW_WORD, 63'h11111111, 1'b0, 1'b1, 32'h11111111, 1'b0},
        '{ROW_WORD, 63'h00000000, 1'b0, 1'b1, 32'h00000000, 1'b0},
        '{ROW_WORD, 63'h52454D42, 1'b0, 1'b1, 32'h52454D42, 1'b0},
        '{ROW_WORD, 63'h01FFFFFF, 1'b1, 1'b1, 32'h01FFFFFF, 1'b0},
        '{ROW_CAP,  63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h8FCE0004, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'hAAAAAAAA, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h55555555, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h52454D42, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h01FFFFFF, 1'b1, 1'b1, 32'h01B9FFFF, 1'b1},
        '{ROW_CAP,  63'h1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'hAFCE0005, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'hFFFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h52454D42, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'hFF000002, 1'b1, 1'b1, 32'hFF000001, 1'b1},
        '{ROW_WORD, 63'h8FCE0003, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h52454D42, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h8FCE0004, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h52454D42, 1'b0, 1'b0, 32'h0, 1'b0},
        '{ROW_WORD, 63'h00000001, 1'b1, 1'b1, 32'h00000001, 1'b0},
        '{ROW_WORD, 63'h4FCE0004, 1'b0, 1'b1, 32'h4FCE0004, 1'b0},
        '{ROW_WORD, 63'h52454D42, 1'b1, 1'b1, 32'h52454D42, 1'b0},
        '{ROW_WORD, 63'h80C80000, 1'b0, 1'b1, 32'h80C80000, 1'b0},
        '{ROW_WORD, 63'h8FCE0004, 1'b1, 1'b1, 32'h8FCE0004, 1'b0}
    };

    logic clk;
    logic rst_n;

    rrbc_word_if   pkt_in_if();
    rrbc_result_if pkt_out_if();
    rrbc_cfg_if    cfg_if();

    rtcp_remb_bitrate_capper_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt_in  (pkt_in_if),
        .pkt_out (pkt_out_if),
        .cfg     (cfg_if)
    );

    // predictor state
    logic [WIDX_W-1:0] word_idx;
    logic [LEN_W-1:0]  sub_len;
    logic              remb_hdr_seen;
    logic              remb_id_ok;
    logic              walk_halted;
    logic              first_word;
    cap_t              cap_limit;

    result_t expected_words[$];
    word_t   packet_words[$];
    int      mismatch_count;
    int      stuck_cycles;
    logic    src_burst;
    logic    sink_burst;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void restart_walk();
        word_idx      = '0;
        sub_len       = '0;
        remb_hdr_seen = 1'b0;
        remb_id_ok    = 1'b0;
        walk_halted   = 1'b0;
        first_word    = 1'b1;
    endfunction

    // smallest exponent, at most 46, that lets the 18-bit mantissa hold the cap
    function automatic logic [23:0] cap_to_exp_mant(cap_t cap);
        logic [63:0] wide;
        int b;
        wide = {1'b0, cap};
        b = 0;
        while (b < 46 && wide > (64'(MANT_MAX) << b))
            b++;
        return {6'(b), 18'(wide >> b)};
    endfunction

    function automatic result_t remb_cap_predict(word_t w, logic last);
        result_t r;
        logic [EXP_W-1:0] e;
        cap_t m;
        r = '{word: w, last: last, capped: 1'b0};
        if (first_word)
        begin
            first_word = 1'b0;
            if (w[31:30] != RTCP_VERSION)
                walk_halted = 1'b1;
        end
        if (!walk_halted)
        begin
            if (word_idx == '0)
            begin
                sub_len       = w[15:0];
                remb_hdr_seen = (w[23:16] == PT_PSFB) && (w[28:24] == FMT_AFB);
                remb_id_ok    = 1'b0;
            end
            else if (word_idx == IDX_REMB_ID && remb_hdr_seen)
            begin
                remb_id_ok = (w == REMB_ID);
            end
            else if (word_idx == IDX_REMB_RATE && remb_hdr_seen && remb_id_ok
                     && cap_limit != '0)
            begin
                e = w[23:18];
                m = CAP_W'(w[17:0]);
                if (m > (cap_limit >> e))
                begin
                    r.word   = {w[31:24], cap_to_exp_mant(cap_limit)};
                    r.capped = 1'b1;
                end
            end
            if (word_idx >= WIDX_W'(sub_len))
            begin
                if (sub_len == '0)
                    walk_halted = 1'b1;
                word_idx = '0;
            end
            else
            begin
                word_idx = word_idx + 1'b1;
            end
        end
        if (last)
            restart_walk();
        return r;
    endfunction

    // rate word: either fully random or close to the current cap
    function automatic word_t make_rate_word(logic [7:0] count);
        logic [23:0] enc;
        logic [5:0]  e;
        logic [17:0] m;
        word_t raw;
        enc = cap_to_exp_mant(cap_limit);
        raw = $urandom;
        if ($urandom_range(0, 9) < 4)
            return {count, raw[23:0]};
        e = enc[23:18];
        m = enc[17:0] + 18'($urandom_range(0, 6)) - 18'd3;
        if ($urandom_range(0, 2) == 0)
        begin
            e = e + 6'($urandom_range(0, 2)) - 6'd1;
            m = raw[17:0];
        end
        return {count, e, m};
    endfunction

    function automatic logic [1:0] header_version(logic first);
        if (!first && $urandom_range(0, 3) == 0)
            return 2'($urandom);
        return RTCP_VERSION;
    endfunction

    function automatic void add_remb_subpacket(logic first);
        int nssrc;
        int flaw;
        logic [4:0]  fmt;
        logic [7:0]  pt;
        logic [15:0] len;
        logic [7:0]  count;
        word_t id;
        nssrc = $urandom_range(0, 3);
        flaw  = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 4) : 0;
        fmt   = FMT_AFB;
        pt    = PT_PSFB;
        len   = 16'(4 + nssrc);
        id    = REMB_ID;
        count = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(nssrc);
        case (flaw)
            1: len = 16'($urandom_range(0, 3));
            2: id = id ^ (32'd1 << $urandom_range(0, 31));
            3: fmt = 5'($urandom);
            4: pt = 8'($urandom);
            default: ;
        endcase
        packet_words.push_back({header_version(first), 1'($urandom), fmt, pt, len});
        packet_words.push_back($urandom);
        packet_words.push_back($urandom);
        packet_words.push_back(id);
        packet_words.push_back(make_rate_word(count));
        repeat (nssrc) packet_words.push_back($urandom);
    endfunction

    function automatic void add_plain_subpacket(logic first);
        logic [15:0] len;
        word_t raw;
        len = 16'($urandom_range(0, 6));
        raw = $urandom;
        packet_words.push_back({header_version(first), raw[29:16], len});
        repeat (len) packet_words.push_back($urandom);
    endfunction

    function automatic void build_packet();
        int nsub;
        int keep;
        word_t raw;
        packet_words.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 8)) packet_words.push_back($urandom);
            return;
        end
        nsub = $urandom_range(1, 3);
        for (int s = 0; s < nsub; s++)
        begin
            if ($urandom_range(0, 99) < 65)
                add_remb_subpacket(s == 0);
            else
                add_plain_subpacket(s == 0);
        end
        if ($urandom_range(0, 99) < 8)
        begin
            raw = $urandom;
            packet_words[0][31:30] = raw[1:0];
        end
        if ($urandom_range(0, 99) < 8)
        begin
            keep = $urandom_range(1, packet_words.size());
            while (packet_words.size() > keep)
                void'(packet_words.pop_back());
        end
    endfunction

    task automatic send_word(word_t w, logic last, logic use_hard, result_t hard_res);
        int gap;
        result_t predicted;
        gap = src_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            pkt_in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt_in_if.valid       <= 1'b1;
        pkt_in_if.packet_word <= w;
        pkt_in_if.is_last     <= last;
        @(posedge clk);
        while (!pkt_in_if.ready) @(posedge clk);
        predicted = remb_cap_predict(w, last);
        expected_words.push_back(use_hard ? hard_res : predicted);
    endtask

    task automatic write_cap(cap_t v);
        pkt_in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.cap_bitrate <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        cap_limit = v;
    endtask

    function automatic void check_result();
        result_t want;
        if (expected_words.size() == 0)
        begin
            $error("out_word: expected none, actual %h", pkt_out_if.out_word);
            mismatch_count++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (pkt_out_if.out_word !== want.word)
            begin
                $error("out_word: expected %h, actual %h", want.word, pkt_out_if.out_word);
                mismatch_count++;
            end
            if (pkt_out_if.out_last !== want.last)
            begin
                $error("out_last: expected %b, actual %b", want.last, pkt_out_if.out_last);
                mismatch_count++;
            end
            if (pkt_out_if.was_capped !== want.capped)
            begin
                $error("was_capped: expected %b, actual %b", want.capped,
                       pkt_out_if.was_capped);
                mismatch_count++;
            end
        end
    endfunction

    // result sink with random stalls
    initial
    begin
        int stall;
        pkt_out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = sink_burst ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 29) == 0)
                sink_burst = !sink_burst;
            if (stall != 0)
            begin
                pkt_out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pkt_out_if.ready <= 1'b1;
            @(posedge clk);
            while (!pkt_out_if.valid) @(posedge clk);
            check_result();
        end
    end

    always @(posedge clk)
    begin
        if ((pkt_in_if.valid && pkt_in_if.ready) || (pkt_out_if.valid && pkt_out_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        cap_t next_cap;
        int phase_items;
        restart_walk();
        cap_limit      = '0;
        mismatch_count = 0;
        stuck_cycles   = 0;
        src_burst      = 1'b0;
        sink_burst     = 1'b0;
        rst_n                 <= 1'b0;
        pkt_in_if.valid       <= 1'b0;
        pkt_in_if.packet_word <= '0;
        pkt_in_if.is_last     <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.cap_bitrate    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (STIM_ROWS[i])
        begin
            if (STIM_ROWS[i].kind == ROW_CAP)
                write_cap(STIM_ROWS[i].value);
            else
                send_word(STIM_ROWS[i].value[31:0], STIM_ROWS[i].last, STIM_ROWS[i].hard_exp,
                          '{word: STIM_ROWS[i].exp_word, last: STIM_ROWS[i].last,
                            capped: STIM_ROWS[i].exp_capped});
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: next_cap = 63'd1_500_000;
                1: next_cap = '0;
                2: next_cap = CAP_W'(MANT_MAX);
                3: next_cap = 63'h40000;
                4: next_cap = '1;
                5: next_cap = 63'd1;
                default: next_cap = cap_t'({$urandom, $urandom}) >> $urandom_range(0, 62);
            endcase
            write_cap(next_cap);
            phase_items = 0;
            while (phase_items < 48)
            begin
                build_packet();
                src_burst = ($urandom_range(0, 4) == 0);
                foreach (packet_words[i])
                    send_word(packet_words[i], i == packet_words.size() - 1, 1'b0, '0);
                phase_items += packet_words.size();
            end
        end

        pkt_in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
